>>> rtl/core/afd_pkg.sv
// Shared types and constants for the ADPCM frame decoder.
`timescale 1ns / 1ps
`default_nettype none
package afd_pkg;

    localparam int SAMPLES_PER_FRAME = 14;
    localparam int CFG_W             = 64;
    localparam int CFG_IDX_W         = 3;
    localparam int NUM_CFG           = 4;
    localparam int PCM_W             = 16;
    localparam int FRAME_W           = 64;
    localparam int NIB_BITS_W        = 56;
    localparam int COUNT_W           = 4;

    // Operation codes carried in the opcode field of an input transfer.
    localparam logic OP_SEED   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // Step counter and jump condition codes of the microprogram.
    typedef logic [1:0] t_step;
    typedef logic [1:0] t_cond;

    localparam t_cond COND_GOTO  = 2'd0;
    localparam t_cond COND_START = 2'd1;
    localparam t_cond COND_LOOP  = 2'd2;

    // One control word of the microprogram.
    typedef struct packed {
        logic  in_rdy;
        logic  mul_en;
        logic  sum_en;
        logic  emit_en;
        t_cond cond;
        t_step target;
    } t_ctrl;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic start;
        logic out_free;
        logic last;
    } t_stat;

endpackage
`default_nettype wire

>>> rtl/core/afd_in_if.sv
// Input channel interface: one frame or seed operation per transfer.
`timescale 1ns / 1ps
`default_nettype none
interface afd_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [63:0]        frame_bytes;
    logic [3:0]         emit_count;
    logic signed [15:0] seed_newer;
    logic signed [15:0] seed_older;

    modport source (
        output valid, opcode, frame_bytes, emit_count, seed_newer, seed_older,
        input  ready
    );
    modport sink (
        input  valid, opcode, frame_bytes, emit_count, seed_newer, seed_older,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/core/afd_out_if.sv
// Output channel interface: one decoded sample per transfer.
`timescale 1ns / 1ps
`default_nettype none
interface afd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pcm_sample;
    logic               last_of_frame;

    modport source (
        output valid, pcm_sample, last_of_frame,
        input  ready
    );
    modport sink (
        input  valid, pcm_sample, last_of_frame,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/core/adpcm_frame_decoder_unit.sv
// Top level of the one-channel 4-bit ADPCM frame decoder.
// The decoder takes one operation per transfer on i_frm. A seed operation
// (opcode 0) loads the two-sample history and produces no output. A decode
// operation (opcode 1) carries an 8-byte frame whose header selects a
// scale exponent and one of eight coefficient pairs; it yields as many
// samples as its emit_count field asks for (15 is treated as 14, 0 yields
// nothing) on o_pcm, the last one flagged with last_of_frame. The block takes
// the transfer, then runs three steps of a small microprogram per sample
// (both prediction products, their rounded sum, then scale, add, saturate
// and emit). Each sample depends on the two samples before it, so the
// products of one sample cannot start until the previous sample has been
// emitted into the history. A registered output stage holds the finished
// sample; the emit step waits only while that stage is full and not being
// taken. The four coefficient registers are written through i_cfg_we,
// i_cfg_idx and i_cfg_data; the user must write them only while the block
// is idle, which the block itself does not enforce. Writes to an index
// above three are dropped.
`timescale 1ns / 1ps
`default_nettype none
module adpcm_frame_decoder_unit
    import afd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    afd_in_if.sink                    i_frm,
    afd_out_if.source                 o_pcm
);

    // Control words flow from the sequencer; the datapath reports whether a
    // frame has started, whether the output stage can take a sample and
    // whether the current sample is the last of its frame.
    t_ctrl w_ctrl;
    t_stat w_stat;

    afd_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    afd_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ctrl     (w_ctrl),
        .o_stat     (w_stat),
        .frm        (i_frm),
        .pcm        (o_pcm)
    );

endmodule
`default_nettype wire

>>> rtl/core/afd_useq.sv
// Microcode sequencer: control ROM, step counter and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none
module afd_useq
    import afd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_stat i_stat,
    output t_ctrl      o_ctrl
);

    localparam t_step STEP_IDLE = 2'd0;
    localparam t_step STEP_MUL  = 2'd1;
    localparam t_step STEP_SUM  = 2'd2;
    localparam t_step STEP_EMIT = 2'd3;

    t_step r_step;
    t_step n_step;
    t_ctrl w_ctrl;

    // Control store. Fields: in_rdy, mul_en, sum_en, emit_en, cond, target.
    always_comb begin
        case (r_step)
            STEP_IDLE: w_ctrl = '{1'b1, 1'b0, 1'b0, 1'b0, COND_START, STEP_MUL};
            STEP_MUL:  w_ctrl = '{1'b0, 1'b1, 1'b0, 1'b0, COND_GOTO,  STEP_SUM};
            STEP_SUM:  w_ctrl = '{1'b0, 1'b0, 1'b1, 1'b0, COND_GOTO,  STEP_EMIT};
            STEP_EMIT: w_ctrl = '{1'b0, 1'b0, 1'b0, 1'b1, COND_LOOP,  STEP_MUL};
            default:   w_ctrl = '{1'b1, 1'b0, 1'b0, 1'b0, COND_START, STEP_MUL};
        endcase
    end

    // The emit step waits while the output stage is full, falls through to the next
    // step (wrapping to idle) after the last sample, else loops back to multiply.
    always_comb begin
        case (w_ctrl.cond)
            COND_START: n_step = i_stat.start ? w_ctrl.target : r_step;
            COND_LOOP: begin
                if (!i_stat.out_free) begin
                    n_step = r_step;
                end else if (i_stat.last) begin
                    n_step = r_step + t_step'(1);
                end else begin
                    n_step = w_ctrl.target;
                end
            end
            default:   n_step = w_ctrl.target;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = w_ctrl;

endmodule
`default_nettype wire

>>> rtl/core/afd_dpath.sv
// Decoder datapath: coefficients, history, multipliers, accumulator, output.
`timescale 1ns / 1ps
`default_nettype none
module afd_dpath
    import afd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire t_ctrl                i_ctrl,
    output t_stat                     o_stat,
    afd_in_if.sink                    frm,
    afd_out_if.source                 pcm
);

    localparam int ACC_W = 33;
    localparam int VAL_W = 23;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = 33'sd1024;
    localparam logic signed [VAL_W-1:0] PCM_MIN    = -23'sd32768;
    localparam logic signed [VAL_W-1:0] PCM_MAX    = 23'sd32767;

    logic [CFG_W-1:0] r_cfg [NUM_CFG];

    logic signed [PCM_W-1:0]   r_newer, r_older;
    logic signed [PCM_W-1:0]   r_c1, r_c2;
    logic [3:0]                r_exp;
    logic [NIB_BITS_W-1:0]     r_nibs;
    logic [COUNT_W-1:0]        r_left;
    logic signed [2*PCM_W-1:0] r_p1, r_p2;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_out_valid;
    logic signed [PCM_W-1:0]   r_pcm;
    logic                      r_last;

    logic                    w_accept, w_start, w_seed, w_out_free, w_emit;
    logic [COUNT_W-1:0]      w_count;
    logic [2:0]              w_pred;
    logic [CFG_W-1:0]        w_pair_reg;
    logic signed [VAL_W-1:0] w_shn, w_hist, w_val;
    logic signed [PCM_W-1:0] w_sat;

    assign w_accept   = frm.valid && i_ctrl.in_rdy;
    assign w_count    = (frm.emit_count > COUNT_W'(SAMPLES_PER_FRAME))
                        ? COUNT_W'(SAMPLES_PER_FRAME) : frm.emit_count;
    assign w_start    = w_accept && (frm.opcode == OP_DECODE) && (w_count != '0);
    assign w_seed     = w_accept && (frm.opcode == OP_SEED);
    assign w_out_free = !r_out_valid || pcm.ready;
    assign w_emit     = i_ctrl.emit_en && w_out_free;

    assign w_pred     = frm.frame_bytes[62:60];
    assign w_pair_reg = r_cfg[w_pred[2:1]];

    // Residual scaled by 2^exp, plus the rounded prediction, then saturated.
    assign w_shn  = VAL_W'(signed'(r_nibs[NIB_BITS_W-1 -: 4])) <<< r_exp;
    assign w_hist = VAL_W'(signed'(r_acc[ACC_W-1:11]));
    assign w_val  = w_shn + w_hist;

    always_comb begin
        if (w_val < PCM_MIN) begin
            w_sat = PCM_MIN[PCM_W-1:0];
        end else if (w_val > PCM_MAX) begin
            w_sat = PCM_MAX[PCM_W-1:0];
        end else begin
            w_sat = w_val[PCM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NUM_CFG))) begin
            r_cfg[i_cfg_idx[1:0]] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newer <= '0;
            r_older <= '0;
        end else if (w_seed) begin
            r_newer <= frm.seed_newer;
            r_older <= frm.seed_older;
        end else if (w_emit) begin
            r_newer <= w_sat;
            r_older <= r_newer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (w_start) begin
            r_left <= w_count;
        end else if (w_emit) begin
            r_left <= r_left - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_exp  <= frm.frame_bytes[59:56];
            r_nibs <= frm.frame_bytes[NIB_BITS_W-1:0];
            if (w_pred[0]) begin
                r_c1 <= signed'(w_pair_reg[31:16]);
                r_c2 <= signed'(w_pair_reg[15:0]);
            end else begin
                r_c1 <= signed'(w_pair_reg[63:48]);
                r_c2 <= signed'(w_pair_reg[47:32]);
            end
        end else if (w_emit) begin
            r_nibs <= {r_nibs[NIB_BITS_W-5:0], 4'h0};
        end
        if (i_ctrl.mul_en) begin
            r_p1 <= r_c1 * r_newer;
            r_p2 <= r_c2 * r_older;
        end
        if (i_ctrl.sum_en) begin
            r_acc <= ACC_W'(r_p1) + ACC_W'(r_p2) + ROUND_BIAS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (pcm.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_pcm  <= w_sat;
            r_last <= (r_left == COUNT_W'(1));
        end
    end

    assign frm.ready         = i_ctrl.in_rdy;
    assign pcm.valid         = r_out_valid;
    assign pcm.pcm_sample    = r_pcm;
    assign pcm.last_of_frame = r_last;

    assign o_stat = '{start:    w_start,
                      out_free: w_out_free,
                      last:     (r_left == COUNT_W'(1))};

endmodule
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the one-channel ADPCM frame decoder.
`timescale 1ns / 1ps
module tb
    import afd_pkg::*;
();

    // Coefficient register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDX_MAX = 3'd7;

    // Give the block time to finish before a configuration write, since seeds
    // and empty frames leave no result.
    localparam int SETTLE_CYCLES = 48;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct {
        logic               opcode;
        logic [FRAME_W-1:0] frame;
        logic [COUNT_W-1:0] count;
        logic signed [15:0] seed_newer;
        logic signed [15:0] seed_older;
    } t_frame_op;

    typedef struct {
        logic signed [PCM_W-1:0] pcm;
        logic                    last;
    } t_pcm_result;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    afd_in_if  frm_if ();
    afd_out_if pcm_if ();

    adpcm_frame_decoder_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_frm      (frm_if),
        .o_pcm      (pcm_if)
    );

    // Operations waiting to be offered, and the samples the decoder owes us.
    t_frame_op   op_queue[$];
    t_pcm_result sample_queue[$];

    // Our own copy of the decoder state and its coefficient bank.
    logic [CFG_W-1:0]   coef_bank[NUM_CFG];
    logic signed [15:0] hist_newer;
    logic signed [15:0] hist_older;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;

    int mismatch_cnt;
    int frames_sent;
    int seeds_sent;
    int samples_checked;
    int rail_cnt;
    int settings_cnt;

    t_frame_op   drive_op;
    t_pcm_result want;

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        frm_if.valid = 1'b0;
        frm_if.opcode = OP_SEED;
        frm_if.frame_bytes = '0;
        frm_if.emit_count = '0;
        frm_if.seed_newer = '0;
        frm_if.seed_older = '0;
        pcm_if.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        mismatch_cnt = 0;
        frames_sent = 0;
        seeds_sent = 0;
        samples_checked = 0;
        rail_cnt = 0;
        settings_cnt = 0;
        hist_newer = '0;
        hist_older = '0;
        for (int i = 0; i < NUM_CFG; i++) begin
            coef_bank[i] = '0;
        end
    end

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Appends one operation to the list that the sender works through.
    function automatic void queue_op(input t_frame_op op);
        op_queue.insert(op_queue.size(), op);
    endfunction

    // Works out the samples that one accepted operation must produce and
    // advances the predicted history. The prediction is the rounded
    // second-order sum c1*newer + c2*older, shifted down by 11 with floor
    // rounding, plus the residual scaled by 2^exponent, then saturated.
    function automatic void predict_op(input t_frame_op op);
        int unsigned        n_out;
        logic [7:0]         header;
        logic [3:0]         expo;
        logic [2:0]         sel;
        logic [CFG_W-1:0]   pair_reg;
        logic signed [15:0] c1;
        logic signed [15:0] c2;
        logic [7:0]         nib_pair;
        logic signed [3:0]  resid;
        longint             acc;
        longint             val;
        t_pcm_result        res;
        if (op.opcode == OP_SEED) begin
            hist_newer = op.seed_newer;
            hist_older = op.seed_older;
            return;
        end
        // A count of 15 is treated as a full frame; 0 yields nothing.
        n_out = (op.count > SAMPLES_PER_FRAME) ? SAMPLES_PER_FRAME : op.count;
        header = op.frame[63:56];
        expo = header[3:0];
        sel = header[6:4];
        pair_reg = coef_bank[sel[2:1]];
        c1 = sel[0] ? pair_reg[31:16] : pair_reg[63:48];
        c2 = sel[0] ? pair_reg[15:0]  : pair_reg[47:32];
        for (int i = 0; i < n_out; i++) begin
            nib_pair = op.frame[55 - 8 * (i / 2) -: 8];
            resid = (i % 2) ? nib_pair[3:0] : nib_pair[7:4];
            acc = longint'(c1) * longint'(hist_newer)
                + longint'(c2) * longint'(hist_older) + 1024;
            val = longint'(resid) * (longint'(1) << expo) + (acc >>> 11);
            if (val < -32768) begin
                val = -32768;
            end
            if (val > 32767) begin
                val = 32767;
            end
            if (val == -32768 || val == 32767) begin
                rail_cnt++;
            end
            hist_older = hist_newer;
            hist_newer = val[15:0];
            res.pcm = val[15:0];
            res.last = (i + 1 == n_out);
            sample_queue.insert(sample_queue.size(), res);
        end
    endfunction

    function automatic t_frame_op make_decode(input logic [7:0] header,
                                              input logic [55:0] nibbles,
                                              input logic [3:0] count);
        t_frame_op op;
        op.opcode = OP_DECODE;
        op.frame = {header, nibbles};
        op.count = count;
        // The seed fields must not matter for a decode, so fill them.
        op.seed_newer = 16'($urandom);
        op.seed_older = 16'($urandom);
        return op;
    endfunction

    function automatic t_frame_op make_seed(input logic signed [15:0] newer,
                                            input logic signed [15:0] older);
        t_frame_op op;
        op.opcode = OP_SEED;
        // Frame and count are ignored by a seed, so they carry noise.
        op.frame = {$urandom, $urandom};
        op.count = 4'($urandom);
        op.seed_newer = newer;
        op.seed_older = older;
        return op;
    endfunction

    // Mostly well-formed frames with random content, some seeds, and a
    // sprinkling of empty and over-long counts.
    function automatic t_frame_op make_random_op();
        int unsigned pick;
        logic [3:0]  count;
        if ($urandom_range(99) < 12) begin
            return make_seed(16'($urandom), 16'($urandom));
        end
        pick = $urandom_range(99);
        if (pick < 6) begin
            count = 4'd0;
        end else if (pick < 12) begin
            count = 4'd15;
        end else begin
            count = 4'($urandom_range(SAMPLES_PER_FRAME, 1));
        end
        return make_decode(8'($urandom), 56'({$urandom, $urandom}), count);
    endfunction

    // Register writes go out one at a time and are mirrored into our
    // coefficient bank; indexes above three must be dropped by the block.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        if (idx < NUM_CFG) begin
            coef_bank[idx[1:0]] = data;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all_coefs(input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] b,
                                   input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] d);
        write_reg(REG_COEF_A, a);
        write_reg(REG_COEF_B, b);
        write_reg(REG_COEF_C, c);
        write_reg(REG_COEF_D, d);
        settings_cnt++;
    endtask

    // Holds the main sequence until every queued operation has gone out and
    // every owed sample has arrived, then lets a seed or empty frame finish.
    // The check is repeated after the settling time in case an operation
    // was just being placed on the channel when the queues looked empty.
    task automatic wait_idle();
        forever begin
            while (op_queue.size() != 0 || frm_if.valid || sample_queue.size() != 0) begin
                @(posedge clk);
            end
            repeat (SETTLE_CYCLES) @(posedge clk);
            if (op_queue.size() == 0 && !frm_if.valid && sample_queue.size() == 0) begin
                break;
            end
        end
    endtask

    function automatic logic [CFG_W-1:0] random_coefs();
        return {$urandom, $urandom};
    endfunction

    // Sender: a new operation may be placed whenever the channel is empty
    // or the current one transfers at this edge.
    always @(posedge clk) begin
        if (!rst_n) begin
            frm_if.valid <= 1'b0;
        end else if (!frm_if.valid || frm_if.ready) begin
            if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drive_op = op_queue.pop_front();
                frm_if.valid <= 1'b1;
                frm_if.opcode <= drive_op.opcode;
                frm_if.frame_bytes <= drive_op.frame;
                frm_if.emit_count <= drive_op.count;
                frm_if.seed_newer <= drive_op.seed_newer;
                frm_if.seed_older <= drive_op.seed_older;
            end else begin
                frm_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: a long hold-off, when requested, overrides random stalls.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pcm_if.ready <= 1'b0;
        end else begin
            pcm_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predicts on every input transfer and checks every output
    // transfer against the oldest owed sample.
    always @(posedge clk) begin
        if (rst_n) begin
            if (frm_if.valid && frm_if.ready) begin
                predict_op('{frm_if.opcode, frm_if.frame_bytes, frm_if.emit_count,
                             frm_if.seed_newer, frm_if.seed_older});
                if (frm_if.opcode == OP_SEED) begin
                    seeds_sent++;
                end else begin
                    frames_sent++;
                end
            end
            if (pcm_if.valid && pcm_if.ready) begin
                if (sample_queue.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("%0t: unexpected sample %0d last %0b with nothing owed",
                                 $time, pcm_if.pcm_sample, pcm_if.last_of_frame);
                    end
                end else begin
                    want = sample_queue.pop_front();
                    samples_checked++;
                    if (pcm_if.pcm_sample !== want.pcm
                            || pcm_if.last_of_frame !== want.last) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("%0t: expected sample %0d last %0b, got %0d last %0b",
                                     $time, want.pcm, want.last,
                                     pcm_if.pcm_sample, pcm_if.last_of_frame);
                        end
                    end
                end
            end
        end
    end

    // Main sequence: reset, a directed set, then random phases that each
    // bring their own coefficient setting and idling pattern.
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pair 0 holds the extreme positive and negative coefficients, pair 2 both
        // most negative, pair 6 both most positive, pair 7 zero, the rest moderate.
        write_all_coefs({16'h7FFF, 16'h8000, 16'h0800, 16'hFC00},
                        {16'h8000, 16'h8000, 16'h0400, 16'h0400},
                        {16'h1000, 16'h0000, 16'h0000, 16'h1000},
                        {16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000});
        // Writes to unused indexes must leave the bank alone.
        for (int i = NUM_CFG; i <= REG_IDX_MAX; i++) begin
            write_reg(CFG_IDX_W'(i), random_coefs());
        end

        // Saturation at both rails with the largest exponent.
        queue_op(make_seed(16'sh7FFF, -16'sh8000));
        queue_op(make_decode(8'h0F, {14{4'h7}}, 4'd14));
        queue_op(make_decode(8'h0F, {14{4'h8}}, 4'd14));
        // Most negative history times most negative coefficients.
        queue_op(make_seed(-16'sh8000, -16'sh8000));
        queue_op(make_decode(8'h20, 56'h0, 4'd14));
        // An empty frame must not touch the history; 15 means a full frame.
        queue_op(make_decode(8'h10, 56'({$urandom, $urandom}), 4'd0));
        queue_op(make_decode(8'h1C, 56'({$urandom, $urandom}), 4'd15));
        // Header bit 7 is ignored.
        queue_op(make_decode(8'hF3, 56'({$urandom, $urandom}), 4'd1));
        queue_op(make_decode(8'h00, 56'h0, 4'd14));
        queue_op(make_decode(8'hFF, {56{1'b1}}, 4'd14));
        // Every predictor pair once, with a spread of exponents and counts.
        for (int p = 0; p < 8; p++) begin
            queue_op(make_decode({1'b0, 3'(p), 4'(2 * p)},
                                 56'({$urandom, $urandom}), 4'(14 - p)));
        end
        queue_op(make_seed(16'sh0000, 16'sh0000));
        queue_op(make_decode(8'h60, {7{8'h78}}, 4'd14));
        wait_idle();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_all_coefs(random_coefs(), random_coefs(),
                                    random_coefs(), random_coefs());
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    // The receiver goes quiet while the sender keeps
                    // offering, so the block has to stall its input.
                    hold_left <= HOLD_OFF_CYCLES;
                end
                1: begin
                    write_all_coefs({4{16'h7FFF}}, {4{16'h7FFF}},
                                    {4{16'h7FFF}}, {4{16'h7FFF}});
                    send_idle_pct = 62;
                    recv_stall_pct = 0;
                end
                2: begin
                    write_all_coefs({4{16'h8000}}, {4{16'h8000}},
                                    {4{16'h8000}}, {4{16'h8000}});
                    send_idle_pct = 0;
                    recv_stall_pct = 62;
                end
                3: begin
                    write_all_coefs('0, '0, '0, '0);
                    send_idle_pct = 28;
                    recv_stall_pct = 28;
                end
                default: begin
                    write_all_coefs(random_coefs(), {64{1'b1}},
                                    random_coefs(), random_coefs());
                    send_idle_pct = 28;
                    recv_stall_pct = 28;
                end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Halfway through one phase the sequence waits for the block
                // to drain completely before it goes on.
                if (ph == 3 && k == ITEMS_PER_PHASE / 2) begin
                    wait_idle();
                end
                queue_op(make_random_op());
            end
            wait_idle();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d frames and %0d seeds under %0d coefficient settings;",
                 frames_sent, seeds_sent, settings_cnt);
        $display("checked %0d samples, %0d of them clamped, %0d mismatches.",
                 samples_checked, rail_cnt, mismatch_cnt);
        if (mismatch_cnt == 0 && sample_queue.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog in case the decoder hangs or drops samples.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
